[hdl/tcrc_pkg.sv]
// ----------------------------------------------------------------------------
// tcrc_pkg: shared types and constants of the rotation counter
// Control word layout, microcode table, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package tcrc_pkg;

    // Default values of the top-level parameters.
    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int SAMPLE_WIDTH_DEF = 8;

    // Fixed field widths.
    localparam int RAW_W   = 8;   // raw channel reading
    localparam int TEMP_W  = 8;   // temperature
    localparam int SLOPE_W = 16;  // Q8.8 slope
    localparam int TNORM_W = 9;   // temperature - 25
    localparam int PROD_W  = SLOPE_W + TNORM_W;
    localparam int COMPV_W = PROD_W + 1;      // sample*256 - product
    localparam int COMPQ_W = COMPV_W - 8;     // after the divide by 256
    localparam int STEP_W  = 3;               // step_x / step_y
    localparam int OUT_COUNT_W = 32;

    localparam int REF_TEMP = 25;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_ONE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_TWO = 1'b1;

    // Sequencer program.
    localparam int PC_W = 3;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_MUL_ONE,
        OP_COMP_ONE,
        OP_MUL_TWO,
        OP_COMP_TWO,
        OP_OFFSET,
        OP_STEP,
        OP_COMMIT
    } op_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_NO_INPUT,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // One control word per step. A step whose condition holds jumps to its
    // target; otherwise the step counter advances, wrapping from the last
    // step back to the first.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            3'd0:    w = '{op: OP_ACCEPT,   cond: COND_NO_INPUT, target: 3'd0};
            3'd1:    w = '{op: OP_MUL_ONE,  cond: COND_NEXT,     target: 3'd0};
            3'd2:    w = '{op: OP_COMP_ONE, cond: COND_NEXT,     target: 3'd0};
            3'd3:    w = '{op: OP_MUL_TWO,  cond: COND_NEXT,     target: 3'd0};
            3'd4:    w = '{op: OP_COMP_TWO, cond: COND_NEXT,     target: 3'd0};
            3'd5:    w = '{op: OP_OFFSET,   cond: COND_NEXT,     target: 3'd0};
            3'd6:    w = '{op: OP_STEP,     cond: COND_NEXT,     target: 3'd0};
            3'd7:    w = '{op: OP_COMMIT,   cond: COND_OUT_BUSY, target: 3'd7};
            default: w = '{op: OP_ACCEPT,   cond: COND_NO_INPUT, target: 3'd0};
        endcase
        return w;
    endfunction

endpackage

[hdl/two_channel_rotation_counter.sv]
// ----------------------------------------------------------------------------
// two_channel_rotation_counter: temperature-compensated rotation counter
// Compensates a pair of channel readings, tracks a centre, derives a direction
// step and counts rotations, under control of an eight-step microprogram.
// ----------------------------------------------------------------------------
// An item passes the steps accept, multiply and compensate for channel one,
// multiply and compensate for channel two, offset, step and commit; the result
// is registered at commit. One item is taken at a time, since the eight-step
// program shares one 16x9 multiplier and one compensation path between both
// channels. A stalled output holds the program at its last step until the result
// is taken. Reset (aresetn low, synchronous) clears the slopes, the tracked state
// and the count; no memory needs a clearing pass.
module two_channel_rotation_counter
    import tcrc_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SLOPE_W-1:0]   cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,  // sample_one, sample_two, temperature
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata   // rotation_count, step_x, step_y,
                                           // count_changed, zero pad
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int SW1 = SAMPLE_WIDTH + 1;
    localparam int SW2 = SAMPLE_WIDTH + 2;
    localparam int SAT_HI_I = (1 << (SAMPLE_WIDTH - 1)) - 1;
    localparam logic signed [COMPQ_W-1:0] Q_HI = COMPQ_W'(SAT_HI_I);
    localparam logic signed [COMPQ_W-1:0] Q_LO = COMPQ_W'(-SAT_HI_I - 1);

    // Sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uw;
    logic            jump;
    logic            out_busy;

    // Configuration
    logic signed [SLOPE_W-1:0] slope_one_reg, slope_two_reg;

    // Working registers
    logic signed [RAW_W-1:0]   raw_one_reg, raw_two_reg;
    logic signed [TNORM_W-1:0] tnorm_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SW-1:0]      v1_reg, v2_reg;
    logic signed [SW1-1:0]     dx_reg, dy_reg;
    logic [SW1-1:0]            ax_reg, ay_reg;
    logic [SW2-1:0]            div_reg;
    logic signed [STEP_W-1:0]  sx_reg, sy_reg;

    // Architectural state
    logic signed [SW-1:0]      held_one_reg, held_two_reg;
    logic signed [SW-1:0]      centre_x_reg, centre_y_reg;
    logic signed [STEP_W-1:0]  last_step_x_reg;
    logic [COUNT_WIDTH-1:0]    turn_count_reg, turn_count_next;

    // Output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg;

    // Compensation path
    logic signed [SLOPE_W-1:0] slope_sel;
    logic signed [RAW_W-1:0]   raw_sel;
    logic signed [SW-1:0]      held_sel;
    logic signed [COMPV_W-1:0] comp_v;
    logic signed [COMPQ_W-1:0] comp_q;
    logic                      round_up;
    logic signed [SW-1:0]      comp_sat;
    logic signed [SW1-1:0]     band_diff;
    logic signed [SW-1:0]      comp_out;

    // Offset and step path
    logic signed [SW1-1:0]    dx_next, dy_next;
    logic [SW1-1:0]           ax_next, ay_next;
    logic [1:0]               qx, qy;
    logic signed [STEP_W-1:0] sx_next, sy_next;

    // Commit path
    logic signed [SW1-1:0]              cx_wide, cy_wide;
    logic signed [SW-1:0]               centre_x_next, centre_y_next;
    logic                               count_changed;
    logic signed [COUNT_WIDTH+31:0]     count_ext;
    logic                               commit;

    // ------------------------------------------------------------------------
    // Sequencer: step counter and microcode table
    // ------------------------------------------------------------------------
    assign uw       = ucode_rom(pc_reg);
    assign out_busy = m_tvalid_reg && !m_tready;

    always_comb begin
        case (uw.cond)
            COND_NEXT:     jump = 1'b0;
            COND_NO_INPUT: jump = !s_tvalid;
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b0;
        endcase
        pc_next = jump ? uw.target : pc_reg + 1'b1;
    end

    assign s_tready = (uw.op == OP_ACCEPT);
    assign commit   = (uw.op == OP_COMMIT) && !out_busy;

    // ------------------------------------------------------------------------
    // Compensation: trunc0((raw*256 - slope*tnorm) / 256), saturated, then
    // the dead band against the held value of the same channel.
    // ------------------------------------------------------------------------
    always_comb begin
        if (uw.op == OP_COMP_TWO) begin
            raw_sel  = raw_two_reg;
            held_sel = held_two_reg;
        end else begin
            raw_sel  = raw_one_reg;
            held_sel = held_one_reg;
        end
        slope_sel = (uw.op == OP_MUL_TWO) ? slope_two_reg : slope_one_reg;

        comp_v   = (COMPV_W'(raw_sel) <<< 8) - COMPV_W'(prod_reg);
        // An arithmetic shift floors; a negative value with a fraction
        // needs one added to truncate toward zero.
        round_up = comp_v[COMPV_W-1] && (comp_v[7:0] != 8'd0);
        comp_q   = $signed(comp_v[COMPV_W-1:8]) +
                   $signed({{(COMPQ_W-1){1'b0}}, round_up});

        if (comp_q > Q_HI) begin
            comp_sat = SW'(Q_HI);
        end else if (comp_q < Q_LO) begin
            comp_sat = SW'(Q_LO);
        end else begin
            comp_sat = SW'(comp_q);
        end

        band_diff = SW1'(comp_sat) - SW1'(held_sel);
        if ((band_diff == SW1'(1)) || (band_diff == '0) || (band_diff == '1)) begin
            comp_out = held_sel;
        end else begin
            comp_out = comp_sat;
        end
    end

    // ------------------------------------------------------------------------
    // Offsets from the centre and the direction step. The quotient of
    // 2*|d| by |dx|+|dy| is at most two, so two compares settle it.
    // ------------------------------------------------------------------------
    always_comb begin
        dx_next = SW1'(v1_reg) - SW1'(centre_x_reg);
        dy_next = SW1'(v2_reg) - SW1'(centre_y_reg);
        ax_next = dx_next[SW] ? SW1'(-dx_next) : SW1'(dx_next);
        ay_next = dy_next[SW] ? SW1'(-dy_next) : SW1'(dy_next);

        if (ax_reg == '0) begin
            qx = 2'd0;
        end else if (SW2'(ax_reg) >= div_reg) begin
            qx = 2'd2;
        end else if ({ax_reg, 1'b0} >= div_reg) begin
            qx = 2'd1;
        end else begin
            qx = 2'd0;
        end

        if (ay_reg == '0) begin
            qy = 2'd0;
        end else if (SW2'(ay_reg) >= div_reg) begin
            qy = 2'd2;
        end else if ({ay_reg, 1'b0} >= div_reg) begin
            qy = 2'd1;
        end else begin
            qy = 2'd0;
        end

        sx_next = dx_reg[SW] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        sy_next = dy_reg[SW] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end

    // ------------------------------------------------------------------------
    // Commit: centre update, rotation detection, result word
    // ------------------------------------------------------------------------
    always_comb begin
        cx_wide = SW1'(v1_reg) - SW1'(sx_reg);
        cy_wide = SW1'(v2_reg) - SW1'(sy_reg);
        if (cx_wide[SW] != cx_wide[SW-1]) begin
            centre_x_next = cx_wide[SW] ? SW'(Q_LO) : SW'(Q_HI);
        end else begin
            centre_x_next = SW'(cx_wide);
        end
        if (cy_wide[SW] != cy_wide[SW-1]) begin
            centre_y_next = cy_wide[SW] ? SW'(Q_LO) : SW'(Q_HI);
        end else begin
            centre_y_next = SW'(cy_wide);
        end

        // A rotation is the x step leaving the negative half.
        count_changed = !sx_reg[STEP_W-1] && last_step_x_reg[STEP_W-1];
        if (count_changed) begin
            turn_count_next = sy_reg[STEP_W-1] ? turn_count_reg + 1'b1
                                               : turn_count_reg - 1'b1;
        end else begin
            turn_count_next = turn_count_reg;
        end
        count_ext = (COUNT_WIDTH + 32)'($signed(turn_count_next));

        if (commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_one_reg <= '0;
            slope_two_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SLOPE_ONE: slope_one_reg <= cfg_wdata;
                REG_SLOPE_TWO: slope_two_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= '0;
            m_tvalid_reg    <= 1'b0;
            held_one_reg    <= '0;
            held_two_reg    <= '0;
            centre_x_reg    <= '0;
            centre_y_reg    <= '0;
            last_step_x_reg <= '0;
            turn_count_reg  <= '0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
            if (commit) begin
                held_one_reg    <= v1_reg;
                held_two_reg    <= v2_reg;
                centre_x_reg    <= centre_x_next;
                centre_y_reg    <= centre_y_next;
                last_step_x_reg <= sx_reg;
                turn_count_reg  <= turn_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (uw.op)
            OP_ACCEPT: begin
                if (s_tvalid) begin
                    raw_one_reg <= $signed(s_tdata[7:0]);
                    raw_two_reg <= $signed(s_tdata[15:8]);
                    tnorm_reg   <= TNORM_W'($signed(s_tdata[23:16])) -
                                   TNORM_W'(REF_TEMP);
                end
            end
            OP_MUL_ONE, OP_MUL_TWO: prod_reg <= slope_sel * tnorm_reg;
            OP_COMP_ONE:            v1_reg   <= comp_out;
            OP_COMP_TWO:            v2_reg   <= comp_out;
            OP_OFFSET: begin
                dx_reg  <= dx_next;
                dy_reg  <= dy_next;
                ax_reg  <= ax_next;
                ay_reg  <= ay_next;
                div_reg <= SW2'(ax_next) + SW2'(ay_next);
            end
            OP_STEP: begin
                sx_reg <= sx_next;
                sy_reg <= sy_next;
            end
            OP_COMMIT: begin
                if (commit) begin
                    m_tdata_reg <= {1'b0, count_changed, sy_reg, sx_reg,
                                    count_ext[OUT_COUNT_W-1:0]};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_commit_offers: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid)
        else $error("result not offered after commit");

    a_count_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !count_changed) |=> (turn_count_reg == $past(turn_count_reg)))
        else $error("rotation count moved without a detected rotation");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == OP_COMMIT) |->
        (sx_reg != 3'sb011) && (sx_reg != 3'sb100) &&
        (sy_reg != 3'sb011) && (sy_reg != 3'sb100))
        else $error("direction step out of range");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (pc_reg == PC_W'(1)))
        else $error("sequencer did not start after an input transaction");

endmodule

[test/rotation_result_checker.sv]
// ----------------------------------------------------------------------------
// rotation_result_checker: result predictor and comparator for the counter
// Watches the configuration port and both streams, predicts each result from
// the accepted sample pairs and compares it with the result actually taken.
// ----------------------------------------------------------------------------
module rotation_result_checker
    import tcrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SLOPE_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [39:0]          m_tdata,
    output int                   mismatches,
    output int                   pending,
    output int                   results_checked,
    output int                   turns_seen
);

    localparam longint DEAD_BAND = 1;
    localparam longint STEP_GAIN = 2;
    localparam longint SAMPLE_MAX = 127;
    localparam longint SAMPLE_MIN = -128;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] count;
        logic [STEP_W-1:0]      step_x;
        logic [STEP_W-1:0]      step_y;
        logic                   changed;
    } rotation_result_t;

    logic signed [SLOPE_W-1:0]          slope_one;
    logic signed [SLOPE_W-1:0]          slope_two;
    logic signed [SAMPLE_WIDTH_DEF-1:0] held_one;
    logic signed [SAMPLE_WIDTH_DEF-1:0] held_two;
    logic signed [SAMPLE_WIDTH_DEF-1:0] centre_x;
    logic signed [SAMPLE_WIDTH_DEF-1:0] centre_y;
    logic signed [STEP_W-1:0]           last_step_x;
    logic [COUNT_WIDTH_DEF-1:0]         turn_count;

    rotation_result_t results_due[$];

    function automatic longint clamp_sample(input longint v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < SAMPLE_MIN) return SAMPLE_MIN;
        return v;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Division of signed operands truncates toward zero, as the block does.
    function automatic longint compensated(input logic signed [RAW_W-1:0] raw,
                                           input logic signed [SLOPE_W-1:0] slope,
                                           input longint tnorm);
        longint v;
        v = longint'(raw) * 256 - longint'(slope) * tnorm;
        return clamp_sample(v / 256);
    endfunction

    function automatic rotation_result_t advance_rotation(input logic [23:0] item);
        logic signed [RAW_W-1:0]  raw_one;
        logic signed [RAW_W-1:0]  raw_two;
        logic signed [TEMP_W-1:0] temp;
        longint tnorm, v1, v2, dx, dy, span, sx, sy;
        rotation_result_t r;
        raw_one = item[7:0];
        raw_two = item[15:8];
        temp    = item[23:16];
        tnorm   = longint'(temp) - REF_TEMP;
        v1 = compensated(raw_one, slope_one, tnorm);
        v2 = compensated(raw_two, slope_two, tnorm);
        if (magnitude(v1 - held_one) <= DEAD_BAND) v1 = held_one;
        if (magnitude(v2 - held_two) <= DEAD_BAND) v2 = held_two;
        dx = v1 - centre_x;
        dy = v2 - centre_y;
        span = magnitude(dx) + magnitude(dy);
        if (span == 0) span = 1;
        sx = (STEP_GAIN * dx) / span;
        sy = (STEP_GAIN * dy) / span;
        centre_x = clamp_sample(v1 - sx);
        centre_y = clamp_sample(v2 - sy);
        // A turn is seen when the x step leaves the negative half.
        r.changed = (sx >= 0) && (last_step_x < 0);
        if (r.changed)
            turn_count = (sy < 0) ? turn_count + 1'b1 : turn_count - 1'b1;
        last_step_x = sx;
        held_one = v1;
        held_two = v2;
        r.count  = turn_count;
        r.step_x = sx[STEP_W-1:0];
        r.step_y = sy[STEP_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        rotation_result_t got;
        rotation_result_t want;
        if (!aresetn) begin
            slope_one   = '0;
            slope_two   = '0;
            held_one    = '0;
            held_two    = '0;
            centre_x    = '0;
            centre_y    = '0;
            last_step_x = '0;
            turn_count  = '0;
            results_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SLOPE_ONE: slope_one = cfg_wdata;
                    REG_SLOPE_TWO: slope_two = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.count   = m_tdata[31:0];
                got.step_x  = m_tdata[34:32];
                got.step_y  = m_tdata[37:35];
                got.changed = m_tdata[38];
                results_checked++;
                if (got.changed === 1'b1) turns_seen++;
                if (results_due.size() == 0) begin
                    $display("%0t: result transaction with nothing expected: count %0d",
                             $time, $signed(got.count));
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected count %0d step %0d,%0d changed %0b",
                                 $time, $signed(want.count), $signed(want.step_x),
                                 $signed(want.step_y), want.changed);
                        $display("%0t:   actual count %0d step %0d,%0d changed %0b",
                                 $time, $signed(got.count), $signed(got.step_x),
                                 $signed(got.step_y), got.changed);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                results_due.push_back(advance_rotation(s_tdata));
        end
        pending = results_due.size();
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: top of the rotation counter testbench
// Drives reset, slope settings and sample pairs, stalls the result stream at
// random and once for a long stretch, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb
    import tcrc_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 350;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SLOPE_ONE;
    logic [SLOPE_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;

    int mismatches, pending, results_checked, turns_seen;
    int items_sent     = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    bit sender_gaps    = 1'b0;
    bit receiver_gaps  = 1'b0;
    bit hold_req       = 1'b0;

    always #5 aclk = ~aclk;

    two_channel_rotation_counter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rotation_result_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .turns_seen      (turns_seen)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls, and on request one long hold-off.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one sample pair and returns once the transaction has taken place.
    task automatic send_item(input int a, input int b, input int t);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t[7:0], b[7:0], a[7:0]};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_slopes(input logic [SLOPE_W-1:0] one, input logic [SLOPE_W-1:0] two);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SLOPE_ONE;
        cfg_wdata <= one;
        @(posedge aclk);
        cfg_index <= REG_SLOPE_TWO;
        cfg_wdata <= two;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Readings at the field extremes, meant to drive compensation into both
    // saturation limits when the slopes are at their extremes.
    task automatic send_extremes();
        send_item(127, -128, 125);
        send_item(-128, 127, -40);
        send_item(0, 0, 25);
        send_item(5, -5, 26);
        send_item(-1, 1, 24);
        send_item(64, -64, 0);
    endtask

    // Cosine of k times 45 degrees, scaled by 100.
    function automatic int ring_point(input int k);
        case (k % 8)
            0: return 100;
            1: return 71;
            2: return 0;
            3: return -71;
            4: return -100;
            5: return -71;
            6: return 0;
            default: return 71;
        endcase
    endfunction

    // Mostly noisy circles walked in either direction, so that the step turns
    // and the count moves; the rest are isolated random readings.
    task automatic random_phase(input int n_items, input bit with_hold);
        int sent, laps, dir, radius, ox, oy, t, k, step, a, b;
        sent = 0;
        if (with_hold) hold_req = 1'b1;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                laps   = $urandom_range(1, 4);
                dir    = $urandom_range(0, 1) ? 1 : 7;
                radius = $urandom_range(20, 100);
                ox     = int'($urandom_range(0, 40)) - 20;
                oy     = int'($urandom_range(0, 40)) - 20;
                t      = int'($urandom_range(0, 165)) - 40;
                k      = $urandom_range(0, 7);
                for (step = 0; step < laps * 8; step++) begin
                    a = ox + ring_point(k) * radius / 100 + int'($urandom_range(0, 6)) - 3;
                    b = oy + ring_point(k + 6) * radius / 100 + int'($urandom_range(0, 6)) - 3;
                    send_item(a, b, t);
                    k = (k + dir) % 8;
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_item($urandom_range(0, 255), $urandom_range(0, 255),
                              int'($urandom_range(0, 165)) - 40);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Slopes at their reset value: zero offset, both turn directions,
        // the dead band and the field extremes.
        send_item(0, 0, 25);
        send_item(-100, 0, 25);
        send_item(100, 50, 25);
        send_item(-100, 0, 25);
        send_item(0, -100, 25);
        send_item(1, -100, 25);
        send_item(127, 127, 125);
        send_item(-128, -128, -40);
        send_item(-128, 0, -40);
        send_item(-128, 100, 25);
        send_item(-126, 100, 25);
        quiesce();

        set_slopes(16'h7FFF, 16'h8000);
        send_extremes();
        quiesce();
        set_slopes(16'h8000, 16'h7FFF);
        send_extremes();
        quiesce();

        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        set_slopes(SLOPE_W'($urandom_range(0, 512) - 256),
                   SLOPE_W'($urandom_range(0, 512) - 256));
        random_phase(PHASE_ITEMS, 1'b0);
        quiesce();
        set_slopes(SLOPE_W'($urandom), SLOPE_W'($urandom));
        random_phase(PHASE_ITEMS, 1'b1);
        quiesce();
        set_slopes(16'h8000, 16'h0000);
        random_phase(PHASE_ITEMS, 1'b0);
        quiesce();

        // Last part at full rate on both sides.
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        set_slopes(SLOPE_W'($urandom_range(0, 512) - 256),
                   SLOPE_W'($urandom_range(0, 512) - 256));
        random_phase(PHASE_ITEMS, 1'b0);
        quiesce();

        $display("Sent %0d sample pairs under %0d slope settings, one long output stall.",
                 items_sent, settings_used);
        $display("Compared %0d results, %0d of which moved the rotation count.",
                 results_checked, turns_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived.", mismatches, pending);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
